// ===== rtl/nfd_pkg.sv =====
// Shared types, constants and helpers for the notification frame decoder.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package nfd_pkg;

   // Frame geometry
   localparam int MAX_FRAME_BYTES = 65536;
   localparam int HEADER_BYTES    = 144;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 2);
   localparam int ID_WORDS        = 16;
   localparam int UUID_END        = 112;
   localparam int IDX_EPOCH       = 12;
   localparam int IDX_DELIVERY    = 13;
   localparam int IDX_HANDLE      = 14;
   localparam int IDX_GENERATION  = 15;
   localparam int ENV_WORDS       = 10;
   localparam int UUID_WORDS      = 6;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_WORD    = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   // Verdict codes
   localparam logic [3:0] V_OK        = 4'd0;
   localparam logic [3:0] V_TOO_LARGE = 4'd1;
   localparam logic [3:0] V_MALFORMED = 4'd2;
   localparam logic [3:0] V_VERSION   = 4'd3;
   localparam logic [3:0] V_TYPE      = 4'd4;
   localparam logic [3:0] V_RESERVED  = 4'd5;
   localparam logic [3:0] V_PAYLOAD   = 4'd6;
   localparam logic [3:0] V_IDENTITY  = 4'd7;
   localparam logic [3:0] V_EPOCH     = 4'd8;
   localparam logic [3:0] V_DELIVERY  = 4'd9;
   localparam logic [3:0] V_SOURCE    = 4'd10;

   // Frame type codes
   localparam logic [7:0] TYPE_OFFER    = 8'd0;
   localparam logic [7:0] TYPE_ACK      = 8'd1;
   localparam logic [7:0] TYPE_RECEIPT  = 8'd3;
   localparam logic [7:0] TYPE_ATTACHED = 8'd4;
   localparam logic [7:0] TYPE_MAX      = 8'd4;

   localparam logic [7:0] HDR_VERSION   = 8'd2;

   // One queue transaction between the front and the back.
   typedef struct packed {
      logic        has_byte;
      logic        is_end;
      logic [7:0]  data;
      logic [3:0]  verdict;
      logic [2:0]  frame_kind;
      logic [15:0] pcount;
   } nfd_entry_type;

   typedef logic [ID_WORDS-1:0][63:0] nfd_words_type;

   // Expected magic byte at header offsets 0 to 3 ("NXNF").
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0: m = 8'h4e;
         2'd1: m = 8'h58;
         2'd2: m = 8'h4e;
         2'd3: m = 8'h46;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/nfd_queue.sv =====
// Short transaction queue that decouples the header parser from the result sequencer.
// Depends on nfd_pkg for the entry type and the depth.
`default_nettype none
module nfd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire nfd_pkg::nfd_entry_type push_entry,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       empty,
   output nfd_pkg::nfd_entry_type     head
);
   import nfd_pkg::*;

   nfd_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
   end

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/nfd_front.sv =====
// Front part: takes frame bytes, parses the header, holds the identity words
// and judges the frame on its last byte. Depends on nfd_pkg.
`default_nettype none
module nfd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_frame_byte,
   input  wire logic                   req_end_of_frame,
   input  wire logic                   queue_full,
   output logic                        push,
   output nfd_pkg::nfd_entry_type      push_entry,
   input  wire logic                   env_done,
   output nfd_pkg::nfd_words_type      id_words
);
   import nfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       type_ff, type_in;
   logic [31:0]      total_ff, total_in, payload_ff, payload_in;
   logic             magic_ff, magic_in, version_ff, version_in;
   logic             resv_ff, resv_in, uuid_ff, uuid_in;
   logic             env_pending_ff, env_pending_in;
   nfd_words_type    id_ff;

   logic             accept, in_store, forward;
   logic [POS_W-1:0] rel, kept, pcount;
   logic [63:0]      gen_word;
   logic             attached;
   logic [3:0]       verdict;

   assign id_words = id_ff;

   // Hold off identity writes while the previous envelope is still being read.
   assign in_store  = (pos_ff >= POS_W'(16)) && (pos_ff < POS_W'(HEADER_BYTES));
   assign req_stall = queue_full || (env_pending_ff && in_store);
   assign accept    = req_valid && !req_stall;
   assign rel       = pos_ff - POS_W'(16);
   assign forward   = (pos_ff >= POS_W'(HEADER_BYTES)) &&
                      (pos_ff < POS_W'(MAX_FRAME_BYTES));

   // Header field capture and sticky check flags.
   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      type_in    = type_ff;
      resv_in    = resv_ff;
      total_in   = total_ff;
      payload_in = payload_ff;
      uuid_in    = uuid_ff;
      if (pos_ff < POS_W'(4)) begin
         magic_in = magic_ff || (req_frame_byte != magic_byte(pos_ff[1:0]));
      end
      if (pos_ff == POS_W'(4)) begin
         version_in = version_ff || (req_frame_byte != HDR_VERSION);
      end
      if (pos_ff == POS_W'(5)) begin
         type_in = req_frame_byte;
      end
      if ((pos_ff == POS_W'(6)) || (pos_ff == POS_W'(7))) begin
         resv_in = resv_ff || (req_frame_byte != 8'd0);
      end
      if (pos_ff == POS_W'(8)) begin
         total_in = {24'd0, req_frame_byte};
      end else if ((pos_ff > POS_W'(8)) && (pos_ff < POS_W'(12))) begin
         total_in = {total_ff[23:0], req_frame_byte};
      end
      if (pos_ff == POS_W'(12)) begin
         payload_in = {24'd0, req_frame_byte};
      end else if ((pos_ff > POS_W'(12)) && (pos_ff < POS_W'(16))) begin
         payload_in = {payload_ff[23:0], req_frame_byte};
      end
      if ((pos_ff >= POS_W'(16)) && (pos_ff < POS_W'(UUID_END))) begin
         if ((rel[3:0] == 4'd6) && (req_frame_byte[7:4] != 4'h4)) begin
            uuid_in = 1'b1;
         end
         if ((rel[3:0] == 4'd8) && (req_frame_byte[7:6] != 2'b10)) begin
            uuid_in = 1'b1;
         end
      end
      pos_in = (pos_ff <= POS_W'(MAX_FRAME_BYTES)) ? pos_ff + 1'b1 : pos_ff;
   end

   // Verdict on the count after this byte; the generation word may finish now.
   always_comb begin
      gen_word = (pos_ff == POS_W'(HEADER_BYTES - 1)) ?
                 {id_ff[IDX_GENERATION][55:0], req_frame_byte} : id_ff[IDX_GENERATION];
      attached = (type_in == TYPE_RECEIPT) || (type_in == TYPE_ATTACHED);
      kept     = (pos_in > POS_W'(MAX_FRAME_BYTES)) ? POS_W'(MAX_FRAME_BYTES) : pos_in;
      pcount   = (kept >= POS_W'(HEADER_BYTES)) ? kept - POS_W'(HEADER_BYTES) : '0;
      if (pos_in > POS_W'(MAX_FRAME_BYTES)) begin
         verdict = V_TOO_LARGE;
      end else if ((pos_in < POS_W'(HEADER_BYTES)) || magic_in) begin
         verdict = V_MALFORMED;
      end else if (version_in) begin
         verdict = V_VERSION;
      end else if (type_in > TYPE_MAX) begin
         verdict = V_TYPE;
      end else if (resv_in) begin
         verdict = V_RESERVED;
      end else if ((total_in != 32'(pos_in)) ||
                   (payload_in != 32'(pos_in - POS_W'(HEADER_BYTES)))) begin
         verdict = V_MALFORMED;
      end else if (((type_in == TYPE_OFFER) || (type_in == TYPE_ACK) ||
                    (type_in == TYPE_RECEIPT)) && (pos_in != POS_W'(HEADER_BYTES))) begin
         verdict = V_PAYLOAD;
      end else if (uuid_in) begin
         verdict = V_IDENTITY;
      end else if (id_ff[IDX_EPOCH] == 64'd0) begin
         verdict = V_EPOCH;
      end else if (attached ? (id_ff[IDX_DELIVERY] == 64'd0)
                            : (id_ff[IDX_DELIVERY] != 64'd0)) begin
         verdict = V_DELIVERY;
      end else if (attached ? ((id_ff[IDX_HANDLE] == 64'd0) || (gen_word == 64'd0))
                            : ((id_ff[IDX_HANDLE] != 64'd0) || (gen_word != 64'd0))) begin
         verdict = V_SOURCE;
      end else begin
         verdict = V_OK;
      end
   end

   // Queue transaction for a forwarded byte, a frame end, or both.
   always_comb begin
      push                  = accept && (forward || req_end_of_frame);
      push_entry.has_byte   = forward;
      push_entry.is_end     = req_end_of_frame;
      push_entry.data       = req_frame_byte;
      push_entry.verdict    = verdict;
      push_entry.frame_kind = (type_in <= TYPE_MAX) ? type_in[2:0] : 3'd0;
      push_entry.pcount     = pcount[15:0];
      env_pending_in        = env_pending_ff;
      if (env_done) begin
         env_pending_in = 1'b0;
      end
      if (push && req_end_of_frame && (verdict == V_OK)) begin
         env_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         type_ff        <= '0;
         total_ff       <= '0;
         payload_ff     <= '0;
         magic_ff       <= 1'b0;
         version_ff     <= 1'b0;
         resv_ff        <= 1'b0;
         uuid_ff        <= 1'b0;
         env_pending_ff <= 1'b0;
      end else begin
         env_pending_ff <= env_pending_in;
         if (accept && req_end_of_frame) begin
            pos_ff     <= '0;
            type_ff    <= '0;
            total_ff   <= '0;
            payload_ff <= '0;
            magic_ff   <= 1'b0;
            version_ff <= 1'b0;
            resv_ff    <= 1'b0;
            uuid_ff    <= 1'b0;
         end else if (accept) begin
            pos_ff     <= pos_in;
            type_ff    <= type_in;
            total_ff   <= total_in;
            payload_ff <= payload_in;
            magic_ff   <= magic_in;
            version_ff <= version_in;
            resv_ff    <= resv_in;
            uuid_ff    <= uuid_in;
         end
      end
   end

   // Identity words fill big-endian, one byte a transaction.
   always_ff @(posedge clock) begin
      if (accept && in_store) begin
         if (rel[2:0] == 3'd0) begin
            id_ff[rel[6:3]] <= {56'd0, req_frame_byte};
         end else begin
            id_ff[rel[6:3]] <= {id_ff[rel[6:3]][55:0], req_frame_byte};
         end
      end
   end

`ifndef SYNTH
   a_guard: assert property (@(posedge clock) disable iff (reset)
      (env_pending_ff && in_store) |-> !accept)
      else $error("identity store written while envelope pending");
`endif

endmodule
`default_nettype wire

// ===== rtl/nfd_back.sv =====
// Back part: turns queue transactions into result transactions through a
// registered output stage. Depends on nfd_pkg.
`default_nettype none
module nfd_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   queue_empty,
   input  wire nfd_pkg::nfd_entry_type head,
   output logic                        pop,
   output logic                        env_done,
   input  wire nfd_pkg::nfd_words_type id_words,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_item_kind,
   output logic [7:0]                  rsp_payload_data,
   output logic [3:0]                  rsp_word_number,
   output logic [63:0]                 rsp_word_upper,
   output logic [63:0]                 rsp_word_lower,
   output logic [3:0]                  rsp_verdict,
   output logic [2:0]                  rsp_kind_of_frame,
   output logic [15:0]                 rsp_payload_count,
   output logic                        rsp_run_end
);
   import nfd_pkg::*;

   logic        valid_ff, valid_in;
   logic        byte_done_ff, byte_done_in;
   logic [3:0]  word_ff, word_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [3:0]  wnum_ff, wnum_in, verd_ff, verd_in;
   logic [63:0] up_ff, up_in, lo_ff, lo_in;
   logic [2:0]  fk_ff, fk_in;
   logic [15:0] pc_ff, pc_in;
   logic        end_ff, end_in;
   logic        load;

   assign load = !valid_ff || !rsp_stall;

   // Sequence: payload byte, then envelope words on success, then the verdict.
   always_comb begin
      valid_in     = valid_ff && rsp_stall;
      byte_done_in = byte_done_ff;
      word_in      = word_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      wnum_in      = wnum_ff;
      up_in        = up_ff;
      lo_in        = lo_ff;
      verd_in      = verd_ff;
      fk_in        = fk_ff;
      pc_in        = pc_ff;
      end_in       = end_ff;
      pop          = 1'b0;
      env_done     = 1'b0;
      if (load && !queue_empty) begin
         valid_in = 1'b1;
         data_in  = 8'd0;
         wnum_in  = 4'd0;
         up_in    = 64'd0;
         lo_in    = 64'd0;
         verd_in  = V_OK;
         fk_in    = 3'd0;
         pc_in    = 16'd0;
         end_in   = 1'b0;
         if (head.has_byte && !byte_done_ff) begin
            kind_in = KIND_PAYLOAD;
            data_in = head.data;
            if (head.is_end) begin
               byte_done_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else if ((head.verdict == V_OK) && (word_ff < 4'(ENV_WORDS))) begin
            kind_in = KIND_WORD;
            wnum_in = word_ff;
            if (word_ff < 4'(UUID_WORDS)) begin
               up_in = id_words[{word_ff[2:0], 1'b0}];
               lo_in = id_words[{word_ff[2:0], 1'b1}];
            end else begin
               lo_in = id_words[word_ff + 4'(UUID_WORDS)];
            end
            word_in = word_ff + 1'b1;
            if (word_ff == 4'(ENV_WORDS - 1)) begin
               env_done = 1'b1;
            end
         end else begin
            kind_in      = KIND_VERDICT;
            verd_in      = head.verdict;
            fk_in        = head.frame_kind;
            pc_in        = head.pcount;
            end_in       = 1'b1;
            pop          = 1'b1;
            word_in      = 4'd0;
            byte_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         byte_done_ff <= 1'b0;
         word_ff      <= '0;
      end else begin
         valid_ff     <= valid_in;
         byte_done_ff <= byte_done_in;
         word_ff      <= word_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      wnum_ff <= wnum_in;
      up_ff   <= up_in;
      lo_ff   <= lo_in;
      verd_ff <= verd_in;
      fk_ff   <= fk_in;
      pc_ff   <= pc_in;
      end_ff  <= end_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_item_kind     = kind_ff;
   assign rsp_payload_data  = data_ff;
   assign rsp_word_number   = wnum_ff;
   assign rsp_word_upper    = up_ff;
   assign rsp_word_lower    = lo_ff;
   assign rsp_verdict       = verd_ff;
   assign rsp_kind_of_frame = fk_ff;
   assign rsp_payload_count = pc_ff;
   assign rsp_run_end       = end_ff;

`ifndef SYNTH
   a_end_is_verdict: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && end_ff) |-> (kind_ff == KIND_VERDICT))
      else $error("run end on a non-verdict transaction");
   a_word_range: assert property (@(posedge clock) disable iff (reset)
      word_ff <= 4'(ENV_WORDS)) else $error("envelope word counter out of range");
   a_word_after_ok: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == KIND_WORD)) |-> (wnum_ff < 4'(ENV_WORDS)))
      else $error("envelope word number out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/notification_frame_decoder_top.sv =====
// Top level of the notification frame decoder: front parser, queue, back sequencer.
// Depends on nfd_pkg, nfd_front, nfd_queue and nfd_back.
//
// Usage: frame bytes enter on the req_ channel, one transaction per byte, with
// req_end_of_frame on the last byte. Results leave on the rsp_ channel: payload
// bytes (from header offset 144 on) as they arrive, then, for a good frame, the
// ten envelope words, then one verdict transaction with rsp_run_end set.
// A byte passes through a queue slot and then the output register
// before it shows on rsp_.
// Throughput: one byte per cycle while req_stall is low. The end of a good frame adds
// ten envelope words and a verdict; they drain from the four-entry queue while the next
// frame streams in, and its input stalls on header bytes 16 to 143 while the previous
// envelope has not yet been read out, since the identity store is shared.
// Reset (synchronous, active high) empties the queue, drops any result held at
// the output and starts a new frame. When rsp_stall is high the result holds;
// the queue fills and req_stall rises once it is full.
`default_nettype none
module notification_frame_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_end_of_frame,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_item_kind,
   output logic [7:0]       rsp_payload_data,
   output logic [3:0]       rsp_word_number,
   output logic [63:0]      rsp_word_upper,
   output logic [63:0]      rsp_word_lower,
   output logic [3:0]       rsp_verdict,
   output logic [2:0]       rsp_kind_of_frame,
   output logic [15:0]      rsp_payload_count,
   output logic             rsp_run_end
);
   import nfd_pkg::*;

   logic          q_full, q_empty, q_push, q_pop, env_done;
   nfd_entry_type q_in, q_head;
   nfd_words_type id_words;

   nfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_byte   (req_frame_byte),
      .req_end_of_frame (req_end_of_frame),
      .queue_full       (q_full),
      .push             (q_push),
      .push_entry       (q_in),
      .env_done         (env_done),
      .id_words         (id_words)
   );

   nfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   nfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (q_empty),
      .head              (q_head),
      .pop               (q_pop),
      .env_done          (env_done),
      .id_words          (id_words),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_payload_data  (rsp_payload_data),
      .rsp_word_number   (rsp_word_number),
      .rsp_word_upper    (rsp_word_upper),
      .rsp_word_lower    (rsp_word_lower),
      .rsp_verdict       (rsp_verdict),
      .rsp_kind_of_frame (rsp_kind_of_frame),
      .rsp_payload_count (rsp_payload_count),
      .rsp_run_end       (rsp_run_end)
   );

endmodule
`default_nettype wire
